>>> src/cqr_pkg.sv
package cqr_pkg;

	// Fixed-point format of bounds, samples and estimates.
	localparam int FRAC_BITS = 24;
	localparam int TWO_FRAC = 2 * FRAC_BITS;
	localparam int SMALL_SHIFT = TWO_FRAC - 32;

	// Width of a grid step exponent.
	localparam int LG_W = 5;

	// Configuration register indexes.
	localparam logic CFG_METHOD = 1'b0;
	localparam logic CFG_TOL = 1'b1;

	// Sample weight as a left shift: 1, 2 or 4.
	typedef logic [1:0] wsh_t;
	localparam wsh_t W_ONE = 2'd0;
	localparam wsh_t W_TWO = 2'd1;
	localparam wsh_t W_FOUR = 2'd2;

	// One sample point request from the sequencer.
	typedef struct packed {
		logic vld;
		logic signed [31:0] left;
		logic signed [32:0] diff;
		logic [LG_W-1:0] lg;
		wsh_t wsh;
	} pt_ctl_t;

	// Side data carried through the first divider.
	typedef struct packed {
		logic [31:0] mag;
		logic in_unit;
		logic neg;
		wsh_t wsh;
	} crv_side_t;

	// Side data carried through the second divider.
	typedef struct packed {
		logic neg;
		wsh_t wsh;
	} fin_side_t;

endpackage

>>> src/composite_quadrature_refiner_unit.sv
// Per tried count n, the sequencer issues grid + 1 sample points, lets the
// pipeline drain, divides the mean in one step (trapezoidal) or two steps
// (Simpson), then scales and emits; grid is n (trapezoidal) or 2n (Simpson).
// A run tries at most 16 counts. One item is worked on at a time; the sample
// pipeline takes one point per cycle. Reset clears control state and loads
// the registers with method Simpson and tolerance 17.
module composite_quadrature_refiner_unit import cqr_pkg::*; #(
	parameter int MAX_DOUBLINGS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] left_bound,
	input logic signed [31:0] right_bound,
	output logic out_valid,
	input logic out_ready,
	output logic [16:0] interval_count,
	output logic signed [31:0] estimate,
	output logic last,
	output logic not_converged,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [30:0] cfg_data
);

	localparam int JW = MAX_DOUBLINGS + 2;
	localparam int DW_W = $clog2(MAX_DOUBLINGS + 1);

	// Reciprocal of three with 21 fraction bits, rounded up.
	localparam logic [19:0] RECIP3 = 20'd699051;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DIV,
		ST_MUL,
		ST_SAT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic method_q;
	logic [30:0] tol_q;
	logic signed [31:0] left_q;
	logic signed [32:0] diff_q;
	logic simp_q;
	logic [DW_W-1:0] d_q;
	logic [JW-1:0] j_q;
	logic [JW-1:0] ret_q;
	logic signed [63:0] acc_q;
	logic [33:0] dvd_q;
	logic [1:0] rem_q;
	logic [31:0] quo_q;
	logic cnt_q;
	logic neg_q;
	logic [64:0] prod_q;
	logic signed [31:0] est_q;
	logic signed [31:0] prev_q;
	logic out_valid_q;
	logic [16:0] count_q;
	logic signed [31:0] est_out_q;
	logic last_q;
	logic nconv_q;

	// Grid of the current count.
	logic [LG_W-1:0] lg;
	logic [JW-1:0] grid;
	assign lg = LG_W'(d_q) + LG_W'(simp_q);
	assign grid = JW'(1) << lg;

	// Sample point request.
	pt_ctl_t pt;
	wsh_t wsh;
	always_comb begin
		if (j_q == '0 || j_q == grid) begin
			wsh = W_ONE;
		end else if (simp_q && j_q[0]) begin
			wsh = W_FOUR;
		end else begin
			wsh = W_TWO;
		end
		pt.vld = (state_q == ST_ISSUE);
		pt.left = left_q;
		pt.diff = diff_q;
		pt.lg = lg;
		pt.wsh = wsh;
	end

	logic f_vld;
	logic signed [34:0] f_w;

	cqr_curve_pipe #(
		.JW(JW)
	) u_curve (
		.clk(clk),
		.arst_n(arst_n),
		.pt(pt),
		.j(j_q),
		.f_vld(f_vld),
		.f_w(f_w)
	);

	// Mean division step and scaling helpers.
	logic [63:0] abs_acc;
	logic [18:0] div_in;
	logic [38:0] div_prod;
	logic [16:0] div_quo;
	logic [1:0] div_rem;
	logic [32:0] abs_diff;
	logic [40:0] p_sh;
	logic signed [31:0] est_sat;
	logic signed [32:0] delta;
	logic [32:0] abs_delta;
	logic conv;
	logic is_last;
	logic out_free;

	always_comb begin
		abs_acc = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		// Division by three, upper 17 dividend bits first, then the lower 17
		// bits behind the remainder.
		div_in = cnt_q ? {rem_q, dvd_q[16:0]} : {2'b00, dvd_q[33:17]};
		div_prod = 39'(div_in) * 39'(RECIP3);
		div_quo = 17'(div_prod >> 21);
		div_rem = 2'(div_in - 19'({div_quo, 1'b0}) - 19'(div_quo));
		abs_diff = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		p_sh = 41'(prod_q >> FRAC_BITS);
		if (neg_q) begin
			est_sat = (p_sh > 41'h0080000000) ? 32'sh80000000 : 32'(-$signed({1'b0, p_sh}));
		end else begin
			est_sat = (p_sh > 41'h007FFFFFFF) ? 32'sh7FFFFFFF : 32'(p_sh);
		end
		delta = 33'(est_q) - 33'(prev_q);
		abs_delta = delta[32] ? 33'(-delta) : 33'(delta);
		conv = (d_q > DW_W'(1)) && (abs_delta <= 33'(tol_q));
		is_last = conv || (d_q == DW_W'(MAX_DOUBLINGS));
		out_free = !out_valid_q || out_ready;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Run sequencer, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			method_q <= 1'b1;
			tol_q <= 31'd17;
			left_q <= '0;
			diff_q <= '0;
			simp_q <= 1'b0;
			d_q <= '0;
			j_q <= '0;
			ret_q <= '0;
			acc_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= 1'b0;
			neg_q <= 1'b0;
			prod_q <= '0;
			est_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
			count_q <= '0;
			est_out_q <= '0;
			last_q <= 1'b0;
			nconv_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_METHOD: method_q <= cfg_data[0];
					CFG_TOL: tol_q <= cfg_data;
					default: ;
				endcase
			end
			// A new item loaded in the emit state replaces the one taken here.
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			if (f_vld) begin
				acc_q <= acc_q + 64'(f_w);
				ret_q <= ret_q + JW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						left_q <= left_bound;
						diff_q <= 33'(right_bound) - 33'(left_bound);
						simp_q <= method_q;
						d_q <= DW_W'(1);
						j_q <= '0;
						ret_q <= '0;
						acc_q <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					j_q <= j_q + JW'(1);
					if (j_q == grid) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ret_q == grid + JW'(1)) begin
						dvd_q <= 34'(abs_acc >> (LG_W'(d_q) + LG_W'(1)));
						rem_q <= '0;
						cnt_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!simp_q) begin
						quo_q <= 32'(dvd_q);
						state_q <= ST_MUL;
					end else if (!cnt_q) begin
						quo_q[31:17] <= 15'(div_quo);
						rem_q <= div_rem;
						cnt_q <= 1'b1;
					end else begin
						quo_q[16:0] <= div_quo;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= 65'(quo_q) * 65'(abs_diff);
					neg_q <= acc_q[63] ^ diff_q[32];
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					est_q <= est_sat;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q <= 17'(JW'(1) << d_q);
						est_out_q <= est_q;
						last_q <= is_last;
						nconv_q <= is_last && !conv;
						prev_q <= est_q;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							d_q <= d_q + DW_W'(1);
							j_q <= '0;
							ret_q <= '0;
							acc_q <= '0;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign interval_count = count_q;
	assign estimate = est_out_q;
	assign last = last_q;
	assign not_converged = nconv_q;

endmodule

>>> src/cqr_div_pipe.sv
module cqr_div_pipe import cqr_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 34,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	input logic [SW-1:0] side_in,
	output logic out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic vld_s [QW+1];

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(num);
		den_s[0] <= den;
		quo_s[0] <= '0;
		side_s[0] <= side_in;
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW-1:0] trial;
		logic fits;

		assign trial = RW'(den_s[k]) << (QW - 1 - k);
		assign fits = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k+1] <= quo_s[k] | (fits ? (QW'(1) << (QW - 1 - k)) : '0);
			side_s[k+1] <= side_s[k];
		end

		if (k < QW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				rem_s[k+1] <= fits ? (rem_s[k] - trial) : rem_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign quo = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

>>> src/cqr_curve_pipe.sv
module cqr_curve_pipe import cqr_pkg::*; #(
	parameter int JW = 18
) (
	input logic clk,
	input logic arst_n,
	input pt_ctl_t pt,
	input logic [JW-1:0] j,
	output logic f_vld,
	output logic signed [34:0] f_w
);

	localparam int PW = 34 + JW;
	localparam int SIDE_W = $bits(crv_side_t);
	localparam int FIN_W = $bits(fin_side_t);

	// Stage 1: span times point index.
	logic vld_s1;
	logic signed [PW-1:0] prod_s1;
	logic signed [31:0] left_s1;
	logic [LG_W-1:0] lg_s1;
	wsh_t wsh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= pt.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(pt.diff * $signed({1'b0, j}));
		left_s1 <= pt.left;
		lg_s1 <= pt.lg;
		wsh_s1 <= pt.wsh;
	end

	// Stage 2: divide by the grid toward zero, add the lower bound, take magnitude.
	logic signed [PW-1:0] bias;
	logic signed [PW-1:0] shifted;
	logic signed [33:0] x_pt;
	logic vld_s2;
	logic [31:0] mag_s2;
	logic neg_s2;
	wsh_t wsh_s2;

	always_comb begin
		bias = prod_s1[PW-1] ? $signed((PW'(1) << lg_s1) - PW'(1)) : '0;
		shifted = (prod_s1 + bias) >>> lg_s1;
		x_pt = 34'(left_s1) + 34'(shifted);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= x_pt[33] ? 32'(-x_pt) : 32'(x_pt);
		neg_s2 <= x_pt[33];
		wsh_s2 <= wsh_s1;
	end

	// Stage 3: square of the magnitude.
	logic vld_s3;
	logic [63:0] u_s3;
	logic [31:0] mag_s3;
	logic neg_s3;
	wsh_t wsh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		u_s3 <= 64'(mag_s2) * 64'(mag_s2);
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		wsh_s3 <= wsh_s2;
	end

	// Stage 4: range test and leading-one search for the normalizing shift.
	logic [6:0] blen;
	logic vld_s4;
	logic [63:0] u_s4;
	logic [5:0] k_s4;
	logic small_s4;
	logic [31:0] mag_s4;
	logic neg_s4;
	wsh_t wsh_s4;

	always_comb begin
		blen = '0;
		for (int i = 0; i < 64; i++) begin
			if (u_s3[i]) begin
				blen = 7'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		u_s4 <= u_s3;
		k_s4 <= (blen > 7'd33) ? 6'(blen - 7'd33) : '0;
		small_s4 <= u_s3 <= (64'(1) << TWO_FRAC);
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		wsh_s4 <= wsh_s3;
	end

	// Stage 5: ratio operands, then r = ns * 2^30 / ms.
	logic [33:0] ms;
	logic [33:0] ns_raw;
	logic [33:0] ns;
	crv_side_t side5;
	logic r_vld;
	logic [30:0] r_quo;
	crv_side_t r_side;

	always_comb begin
		if (small_s4) begin
			ms = 34'(1) << 32;
			ns_raw = 34'(u_s4 >> SMALL_SHIFT);
		end else begin
			ms = 34'(u_s4 >> k_s4);
			ns_raw = 34'(1) << (6'(TWO_FRAC) - k_s4);
		end
		ns = (ns_raw > ms) ? ms : ns_raw;
		side5.mag = mag_s4;
		side5.in_unit = small_s4;
		side5.neg = neg_s4;
		side5.wsh = wsh_s4;
	end

	cqr_div_pipe #(
		.NW(64),
		.DW(34),
		.QW(31),
		.SW(SIDE_W)
	) u_ratio_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s4),
		.num({ns, 30'b0}),
		.den(ms),
		.side_in(side5),
		.out_vld(r_vld),
		.quo(r_quo),
		.side_out(r_side)
	);

	// Stage 6: s = r^2 / 2^30.
	logic [61:0] rr;
	logic vld_s6;
	logic [30:0] s_s6;
	crv_side_t side_s6;

	assign rr = 62'(r_quo) * 62'(r_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		s_s6 <= rr[60:30];
		side_s6 <= r_side;
	end

	// Stage 7: numerator and denominator of the final quotient.
	logic vld_s7;
	logic [61:0] num_s7;
	logic [31:0] den_s7;
	fin_side_t fin_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		num_s7 <= side_s6.in_unit ? (62'(side_s6.mag) << 30) : 62'(side_s6.mag) * 62'(s_s6);
		den_s7 <= (32'(1) << 30) + 32'(s_s6);
		fin_s7.neg <= side_s6.neg;
		fin_s7.wsh <= side_s6.wsh;
	end

	logic q_vld;
	logic [31:0] q_quo;
	fin_side_t q_side;

	cqr_div_pipe #(
		.NW(62),
		.DW(32),
		.QW(32),
		.SW(FIN_W)
	) u_final_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s7),
		.num(num_s7),
		.den(den_s7),
		.side_in(fin_s7),
		.out_vld(q_vld),
		.quo(q_quo),
		.side_out(q_side)
	);

	// Stage 8: restore the sign and apply the sample weight.
	logic signed [32:0] fval;
	logic vld_s8;
	logic signed [34:0] fw_s8;

	assign fval = q_side.neg ? -$signed({1'b0, q_quo}) : $signed({1'b0, q_quo});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= q_vld;
		end
	end

	always_ff @(posedge clk) begin
		fw_s8 <= 35'(fval) <<< q_side.wsh;
	end

	assign f_vld = vld_s8;
	assign f_w = fw_s8;

endmodule

>>> dv/composite_quadrature_refiner_unit_test.sv
`timescale 1ns / 1ps

module composite_quadrature_refiner_unit_test import cqr_pkg::*;;

	localparam int NUM_DOUBLINGS = 16;
	localparam int IDLE_LIMIT = 1200000;
	localparam int RANDOM_ITEMS = 80;

	// One emitted estimate of a refinement run.
	typedef struct {
		logic [16:0] count;
		logic signed [31:0] value;
		logic is_last;
		logic no_conv;
	} estimate_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		bit typed;
	} bounds_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] left_bound;
	logic signed [31:0] right_bound;
	logic out_valid;
	logic out_ready;
	logic [16:0] interval_count;
	logic signed [31:0] estimate;
	logic last;
	logic not_converged;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [30:0] cfg_data;

	// Working copy of the block's registers and run state.
	logic use_simpson;
	logic [30:0] conv_tol;
	longint prior_estimate;

	estimate_t pending_estimates[$];
	int error_count;
	int items_sent;
	int results_seen;
	int limit_runs;
	int idle_cycles;
	bit stall_quiet;

	composite_quadrature_refiner_unit #(.MAX_DOUBLINGS(NUM_DOUBLINGS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_bound(left_bound),
		.right_bound(right_bound),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.interval_count(interval_count),
		.estimate(estimate),
		.last(last),
		.not_converged(not_converged),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Evaluates x / (1 + x^4) in fixed point, folding large x through 1/x^2.
	function automatic longint curve_value(longint x);
		longint unsigned mag, sq, num, den_s, ratio, ratio_sq, denom, quot;
		int bits, shift;
		bit near_zero;
		mag = (x < 0) ? -x : x;
		if (mag > 64'h8000_0000) mag = 64'h8000_0000;
		sq = mag * mag;
		near_zero = sq <= (64'd1 << TWO_FRAC);
		if (near_zero) begin
			den_s = 64'd1 << 32;
			num = sq >> SMALL_SHIFT;
		end else begin
			bits = 0;
			for (longint unsigned t = sq; t != 0; t = t >> 1) bits++;
			shift = (bits > 33) ? bits - 33 : 0;
			den_s = sq >> shift;
			num = 64'd1 << (TWO_FRAC - shift);
		end
		if (den_s == 0) den_s = 1;
		if (num > den_s) num = den_s;
		ratio = (num << 30) / den_s;
		ratio_sq = (ratio * ratio) >> 30;
		denom = (64'd1 << 30) + ratio_sq;
		quot = near_zero ? (mag << 30) / denom : (mag * ratio_sq) / denom;
		return (x < 0) ? -longint'(quot) : longint'(quot);
	endfunction

	// Scales the weighted sample mean by the span, saturating to 32 bits.
	function automatic longint scaled_area(longint total, longint weight, longint span);
		longint mean;
		longint unsigned m, d, p;
		bit neg;
		mean = total / weight;
		neg = (mean < 0) != (span < 0);
		m = (mean < 0) ? -mean : mean;
		d = (span < 0) ? -span : span;
		if (m != 0 && d > 64'hFFFF_FFFF_FFFF_FFFF / m) p = 64'hFFFF_FFFF_FFFF_FFFF;
		else p = (m * d) >> FRAC_BITS;
		if (neg) begin
			if (p > 64'h8000_0000) p = 64'h8000_0000;
			return -longint'(p);
		end
		if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
		return longint'(p);
	endfunction

	// Works out the whole refinement run of one item and queues its estimates.
	task automatic queue_refinement(input logic signed [31:0] lo, input logic signed [31:0] hi);
		longint span, n, grid, weight, acc, pt, est, delta;
		int w;
		bit conv, fin;
		estimate_t r;
		span = longint'(hi) - longint'(lo);
		for (int d = 1; d <= NUM_DOUBLINGS; d++) begin
			n = longint'(1) << d;
			grid = use_simpson ? 2 * n : n;
			weight = use_simpson ? 6 * n : 2 * n;
			acc = 0;
			for (longint j = 0; j <= grid; j++) begin
				pt = longint'(lo) + (span * j) / grid;
				if (j == 0 || j == grid) w = 1;
				else if (use_simpson && j[0]) w = 4;
				else w = 2;
				acc += w * curve_value(pt);
			end
			est = scaled_area(acc, weight, span);
			delta = est - prior_estimate;
			if (delta < 0) delta = -delta;
			conv = (d > 1) && (delta <= longint'(conv_tol));
			fin = conv || (d == NUM_DOUBLINGS);
			r.count = n[16:0];
			r.value = est[31:0];
			r.is_last = fin;
			r.no_conv = fin && !conv;
			pending_estimates.push_back(r);
			prior_estimate = est;
			if (fin) break;
		end
		if (!conv) limit_runs++;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("error at %0t: %s is %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Checks every accepted estimate against the oldest expectation.
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_estimates.size() == 0) begin
				report_mismatch("unexpected result count", interval_count, 0);
			end else begin
				e = pending_estimates.pop_front();
				if (interval_count !== e.count)
					report_mismatch("interval_count", interval_count, e.count);
				if (estimate !== e.value) report_mismatch("estimate", estimate, e.value);
				if (last !== e.is_last) report_mismatch("last", last, e.is_last);
				if (not_converged !== e.no_conv)
					report_mismatch("not_converged", not_converged, e.no_conv);
			end
		end
	end

	// The receiver stalls on a random pattern, with quiet stretches of no stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_quiet = ~stall_quiet;
			out_ready <= stall_quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("composite_quadrature_refiner_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [30:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_METHOD) use_simpson = value[0];
		else conv_tol = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Presents one item from the falling edge and holds it until accepted.
	task automatic send_bounds(input logic signed [31:0] lo, input logic signed [31:0] hi,
			input bit typed);
		in_valid = 1'b1;
		left_bound = lo;
		right_bound = hi;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (typed) begin
			// Equal bounds give zero at counts two and four, then converge.
			pending_estimates.push_back('{17'd2, 32'sd0, 1'b0, 1'b0});
			pending_estimates.push_back('{17'd4, 32'sd0, 1'b1, 1'b0});
			prior_estimate = 0;
		end else begin
			queue_refinement(lo, hi);
		end
		@(negedge clk);
		// Bursts of back-to-back items, separated by random gaps.
		if ($urandom_range(0, 2) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic send_random_item();
		logic signed [31:0] lo, hi;
		longint span, top;
		lo = $urandom;
		case ($urandom_range(0, 19))
			0: hi = $urandom;
			1, 2: span = $urandom_range(0, 32'h0400_0000);
			default: span = $urandom_range(0, 32'h0100_0000);
		endcase
		if (hi === 'x || $isunknown(hi)) begin
			// Mostly short spans placed near the origin, some anywhere.
			if ($urandom_range(0, 2) != 0) lo = $signed($urandom_range(0, 32'h0800_0000))
				- 32'sh0400_0000;
			if ($urandom_range(0, 1)) span = -span;
			top = longint'(lo) + span;
			if (top > 64'sh7FFF_FFFF) top = 64'sh7FFF_FFFF;
			if (top < -64'sh8000_0000) top = -64'sh8000_0000;
			hi = top[31:0];
		end
		send_bounds(lo, hi, 1'b0);
	endtask

	bounds_row_t directed_rows[] = '{
		'{32'sh0000_0000, 32'sh0000_0000, 1'b1},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1},
		'{32'sh8000_0000, 32'sh8000_0000, 1'b1},
		'{32'sh0000_0000, 32'sh0100_0000, 1'b0},
		'{32'sh0100_0000, 32'sh0000_0000, 1'b0},
		'{-32'sh0100_0000, 32'sh0100_0000, 1'b0},
		'{32'sh0080_0000, 32'sh0200_0000, 1'b0},
		'{-32'sh0300_0000, -32'sh0040_0000, 1'b0},
		'{32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 1'b0},
		'{32'sh8000_0000, 32'sh8000_0001, 1'b0},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0},
		'{32'sh0000_0001, -32'sh0000_0001, 1'b0}
	};

	initial begin
		int n_items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		left_bound = '0;
		right_bound = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_METHOD;
		cfg_data = '0;
		use_simpson = 1'b1;
		conv_tol = 31'd17;
		prior_estimate = 0;
		error_count = 0;
		items_sent = 0;
		results_seen = 0;
		limit_runs = 0;
		stall_quiet = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed items under the reset settings.
		foreach (directed_rows[i])
			send_bounds(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].typed);
		in_valid = 1'b0;
		wait_drained();

		// Trapezoidal rule at the extreme tolerances, then Simpson's rule at zero tolerance.
		write_register(CFG_METHOD, 31'd0);
		write_register(CFG_TOL, 31'h7FFF_FFFF);
		send_bounds(32'sh0000_0000, 32'sh0200_0000, 1'b0);
		send_bounds(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		in_valid = 1'b0;
		wait_drained();
		write_register(CFG_TOL, 31'd0);
		send_bounds(32'sh0000_0000, 32'sh0000_0000, 1'b0);
		send_bounds(32'sh0040_0000, 32'sh0100_0000, 1'b0);
		in_valid = 1'b0;
		wait_drained();
		write_register(CFG_METHOD, 31'd1);
		send_bounds(-32'sh0100_0000, -32'sh0080_0000, 1'b0);
		in_valid = 1'b0;
		wait_drained();

		// Random items in phases of random settings.
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			write_register(CFG_METHOD, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: write_register(CFG_TOL, 31'd17);
				1: write_register(CFG_TOL, $urandom_range(18, 4096));
				2: write_register(CFG_TOL, $urandom_range(4097, 32'h0010_0000));
				default: write_register(CFG_TOL, $urandom & 32'h7FFF_FFFF);
			endcase
			repeat ($urandom_range(8, 20)) begin
				send_random_item();
				n_items++;
			end
			in_valid = 1'b0;
			wait_drained();
		end

		repeat (300) @(posedge clk);
		if (pending_estimates.size() != 0)
			report_mismatch("estimates still outstanding", pending_estimates.size(), 0);
		$display("Ran %0d bound pairs through both rules and several tolerances,", items_sent);
		$display("checking %0d estimates; %0d runs hit the doubling limit.", results_seen,
			limit_runs);
		if (error_count == 0) begin
			$display("composite_quadrature_refiner_unit: match");
		end else begin
			$display("composite_quadrature_refiner_unit: mismatch");
		end
		$finish;
	end

endmodule
